// ----- rtl/prd_pkg.sv -----
// ----------------------------------------------------------------------------
// prd_pkg: shared types and constants of the PPMd range decoder
// Request and status codes, coder constants and the divider handshake structs.
// ----------------------------------------------------------------------------
`default_nettype none

package prd_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [WORD_W-1:0] TOP_VALUE  = 32'h0100_0000;
  localparam logic [WORD_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam int unsigned       PROB_BITS  = 14;
  localparam logic [2:0]        LOAD_BYTES = 3'd5;

  // request codes
  localparam logic [2:0] REQ_START  = 3'd0;
  localparam logic [2:0] REQ_BYTE   = 3'd1;
  localparam logic [2:0] REQ_THRESH = 3'd2;
  localparam logic [2:0] REQ_DECODE = 3'd3;
  localparam logic [2:0] REQ_BIT    = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_FIRST_BYTE = 2'd1;
  localparam logic [1:0] STAT_DIV_ZERO   = 2'd2;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/ppmd_range_decoder.sv -----
// ----------------------------------------------------------------------------
// ppmd_range_decoder: PPMd7 range decoder core
// Code/range registers with a sequencer over a shared divider and multiplier.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  in       | in_valid/in_ready  | req_type, byte_in, total, start_req, size, size0
//  out      | out_valid/out_ready| count_out, bit_out, bytes_needed, status
//
// Start, byte and unknown requests go from idle to done; bit requests pass
// S_MUL_A and S_MUL_B, decode requests also S_MUL_C. Threshold requests run
// two divisions in the shared radix-2 divider (one when the scaled range is
// zero, none when total is zero). One request is in work at a time; a finished
// result waits in the output register while the next request is accepted.
// Reset is synchronous and leaves the coder as after a start request.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmd_range_decoder
  import prd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [7:0]  byte_in,
  input  wire logic [15:0] total,
  input  wire logic [15:0] start_req,
  input  wire logic [15:0] size,
  input  wire logic [13:0] size0,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] count_out,
  output      logic        bit_out,
  output      logic [1:0]  bytes_needed,
  output      logic [1:0]  status
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b000_0001,
    S_DIV_R = 7'b000_0010,
    S_DIV_C = 7'b000_0100,
    S_MUL_A = 7'b000_1000,
    S_MUL_B = 7'b001_0000,
    S_MUL_C = 7'b010_0000,
    S_DONE  = 7'b100_0000
  } state_t;

  state_t state;

  logic [WORD_W-1:0] code_reg;
  logic [WORD_W-1:0] range_reg;
  logic [2:0]        init_bytes;
  logic              error_flag;

  logic [2:0]        req_q;
  logic [15:0]       start_q;
  logic [15:0]       size_q;
  logic [13:0]       size0_q;

  logic [WORD_W-1:0] res_count;
  logic              res_bit;
  logic              res_div_zero;

  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] mul_a;
  logic [15:0]       mul_b;
  logic [47:0]       mul_full;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              in_fire;
  logic              out_free;
  logic [1:0]        need;

  function automatic logic [1:0] bytes_for(input logic [WORD_W-1:0] r);
    logic [1:0] n;
    if (r >= TOP_VALUE) begin
      n = 2'd0;
    end else if (r[23:16] != 8'd0) begin
      n = 2'd1;
    end else begin
      n = 2'd2;
    end
    return n;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  prd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // divider launch: range/total on accept, code/range after the first quotient
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = range_reg;
    div_req.divisor  = {16'd0, total};
    if (in_fire && req_type == REQ_THRESH && total != 16'd0) begin
      div_req.start = 1'b1;
    end else if (state == S_DIV_R && div_rsp.done && div_rsp.quotient != '0) begin
      div_req.start    = 1'b1;
      div_req.dividend = code_reg;
      div_req.divisor  = div_rsp.quotient;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = range_reg;
    mul_b = size_q;
    if (state == S_MUL_A) begin
      if (req_q == REQ_BIT) begin
        mul_a = range_reg >> PROB_BITS;
        mul_b = {2'd0, size0_q};
      end else begin
        mul_b = start_q;
      end
    end
    mul_full = 48'(mul_a) * 48'(mul_b);
  end

  always_ff @(posedge clk) begin
    prod <= mul_full[WORD_W-1:0];
  end

  assign need = (req_q == REQ_DECODE || req_q == REQ_BIT) ? bytes_for(range_reg) : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      code_reg   <= '0;
      range_reg  <= ALL_ONES;
      init_bytes <= '0;
      error_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // a result loaded in the same cycle keeps the output valid
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (req_type)
              REQ_START: begin
                code_reg   <= '0;
                range_reg  <= ALL_ONES;
                init_bytes <= '0;
                error_flag <= 1'b0;
                state      <= S_DONE;
              end
              REQ_BYTE: begin
                if (init_bytes < LOAD_BYTES) begin
                  if (init_bytes == 3'd0) begin
                    // leading byte is dropped, but must be zero
                    if (byte_in != 8'd0) begin
                      error_flag <= 1'b1;
                    end
                  end else begin
                    code_reg <= {code_reg[23:0], byte_in};
                  end
                  init_bytes <= init_bytes + 3'd1;
                end else begin
                  code_reg  <= {code_reg[23:0], byte_in};
                  range_reg <= {range_reg[23:0], 8'd0};
                end
                state <= S_DONE;
              end
              REQ_THRESH: begin
                state <= (total == 16'd0) ? S_DONE : S_DIV_R;
              end
              REQ_DECODE, REQ_BIT: begin
                state <= S_MUL_A;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DIV_R: begin
          if (div_rsp.done) begin
            range_reg <= div_rsp.quotient;
            state     <= (div_rsp.quotient == '0) ? S_DONE : S_DIV_C;
          end
        end
        S_DIV_C: begin
          if (div_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_MUL_A: begin
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          if (req_q == REQ_BIT) begin
            if (code_reg < prod) begin
              range_reg <= prod;
            end else begin
              code_reg  <= code_reg - prod;
              range_reg <= range_reg - prod;
            end
            state <= S_DONE;
          end else begin
            code_reg <= code_reg - prod;
            state    <= S_MUL_C;
          end
        end
        S_MUL_C: begin
          range_reg <= prod;
          state     <= S_DONE;
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request fields and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_q        <= req_type;
      start_q      <= start_req;
      size_q       <= size;
      size0_q      <= size0;
      res_count    <= (req_type == REQ_THRESH && total == 16'd0) ? ALL_ONES : '0;
      res_bit      <= 1'b0;
      res_div_zero <= (req_type == REQ_THRESH && total == 16'd0);
    end else begin
      if (state == S_DIV_R && div_rsp.done && div_rsp.quotient == '0) begin
        res_count    <= ALL_ONES;
        res_div_zero <= 1'b1;
      end else if (state == S_DIV_C && div_rsp.done) begin
        res_count <= div_rsp.quotient;
      end else if (state == S_MUL_B && req_q == REQ_BIT && code_reg >= prod) begin
        res_bit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      count_out    <= res_count;
      bit_out      <= res_bit;
      bytes_needed <= need;
      status       <= res_div_zero ? STAT_DIV_ZERO : (error_flag ? STAT_FIRST_BYTE : STAT_OK);
    end
  end

`ifndef ASSERT_OFF
  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV_R || state == S_DIV_C))
    else $error("divider finished outside a division step");

  a_init_bytes_bound: assert property (@(posedge clk) disable iff (rst)
    init_bytes <= LOAD_BYTES)
    else $error("load byte count ran past five");

  a_div_zero_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STAT_DIV_ZERO) |-> (count_out == ALL_ONES))
    else $error("zero divisor reported without all-ones count");

  a_done_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished result not moved to output register");
`endif

endmodule

`default_nettype wire

// ----- rtl/prd_div.sv -----
// ----------------------------------------------------------------------------
// prd_div: iterative unsigned divider
// Restoring radix-2 division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module prd_div
  import prd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quot;
  logic [WORD_W-1:0] dvsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;
  logic              ge;

  always_comb begin
    rem_sh = {rem, quot[WORD_W-1]};
    diff   = rem_sh - {1'b0, dvsr};
    ge     = rem_sh >= {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quot <= req.dividend;
      dvsr <= req.divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so the low word holds it
      rem  <= ge ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      quot <= {quot[WORD_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the PPMd7 range decoder core
// A directed table runs first: loading, extremes, zero divisors, sticky
// errors and reserved requests. Random decode streams with noise follow.
// Results are checked against an in-bench copy of the coder state or typed
// rows, with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import prd_pkg::*;

  localparam logic [2:0] REQ_RSVD_5 = 3'd5;
  localparam logic [2:0] REQ_RSVD_6 = 3'd6;
  localparam logic [2:0] REQ_RSVD_7 = 3'd7;

  localparam int DIR_N        = 25;
  localparam int RAND_ITEMS   = 700;
  localparam int QUIET_TAIL   = 80;
  localparam int PAUSE_AT     = 200;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  stream_byte;
    logic [15:0] total;
    logic [15:0] start;
    logic [15:0] size;
    logic [13:0] size0;
  } request_t;

  typedef struct packed {
    logic [31:0] count;
    logic        dbit;
    logic [1:0]  need;
    logic [1:0]  stat;
  } result_t;

  typedef struct packed {
    request_t rq;
    logic     typed;
    result_t  res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  req_type;
  logic [7:0]  byte_in;
  logic [15:0] total;
  logic [15:0] start_req;
  logic [15:0] size;
  logic [13:0] size0;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] count_out;
  logic        bit_out;
  logic [1:0]  bytes_needed;
  logic [1:0]  status;

  // coder state as the bench tracks it
  logic [31:0] code_q;
  logic [31:0] range_q;
  logic [2:0]  load_cnt;
  logic        err_sticky;

  result_t   pending_q[$];
  result_t   mon_want;
  stim_row_t dir_tab[DIR_N];
  int        req_cnt[8];
  int        sent_cnt;
  int        checked_cnt;
  int        err_cnt;
  int        cyc_cnt;
  logic      quiet;
  logic      tx_busy;
  logic      hold_req;

  ppmd_range_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .byte_in      (byte_in),
    .total        (total),
    .start_req    (start_req),
    .size         (size),
    .size0        (size0),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .count_out    (count_out),
    .bit_out      (bit_out),
    .bytes_needed (bytes_needed),
    .status       (status)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [1:0] renorm_bytes(logic [31:0] r);
    logic [31:0] shifted;
    shifted = r << 8;
    if (r >= TOP_VALUE) return 2'd0;
    if (shifted >= TOP_VALUE) return 2'd1;
    return 2'd2;
  endfunction

  // Advance the tracked coder by one request and return its result.
  function automatic result_t decode_step(request_t r);
    result_t     o;
    logic [31:0] bound;
    logic        dz;
    o  = '0;
    dz = 1'b0;
    case (r.req)
      REQ_START: begin
        code_q     = '0;
        range_q    = ALL_ONES;
        load_cnt   = '0;
        err_sticky = 1'b0;
      end
      REQ_BYTE: begin
        if (load_cnt < LOAD_BYTES) begin
          // the first load byte only carries the zero marker
          if (load_cnt == 3'd0) begin
            if (r.stream_byte != 8'd0) err_sticky = 1'b1;
          end else begin
            code_q = {code_q[23:0], r.stream_byte};
          end
          load_cnt = load_cnt + 3'd1;
        end else begin
          code_q  = {code_q[23:0], r.stream_byte};
          range_q = range_q << 8;
        end
      end
      REQ_THRESH: begin
        if (r.total == 16'd0) begin
          dz      = 1'b1;
          o.count = ALL_ONES;
        end else begin
          range_q = range_q / {16'd0, r.total};
          if (range_q == '0) begin
            dz      = 1'b1;
            o.count = ALL_ONES;
          end else begin
            o.count = code_q / range_q;
          end
        end
      end
      REQ_DECODE: begin
        code_q  = code_q - {16'd0, r.start} * range_q;
        range_q = range_q * {16'd0, r.size};
        o.need  = renorm_bytes(range_q);
      end
      REQ_BIT: begin
        bound = (range_q >> PROB_BITS) * {18'd0, r.size0};
        if (code_q < bound) begin
          range_q = bound;
        end else begin
          o.dbit  = 1'b1;
          code_q  = code_q - bound;
          range_q = range_q - bound;
        end
        o.need = renorm_bytes(range_q);
      end
      default: ;
    endcase
    o.stat = dz ? STAT_DIV_ZERO : (err_sticky ? STAT_FIRST_BYTE : STAT_OK);
    return o;
  endfunction

  function automatic request_t mk(logic [2:0] q, logic [7:0] b, logic [15:0] t,
                                  logic [15:0] s, logic [15:0] z, logic [13:0] p);
    request_t r;
    r.req         = q;
    r.stream_byte = b;
    r.total       = t;
    r.start       = s;
    r.size        = z;
    r.size0       = p;
    return r;
  endfunction

  function automatic result_t rs(logic [31:0] c, logic b, logic [1:0] n, logic [1:0] st);
    result_t o;
    o.count = c;
    o.dbit  = b;
    o.need  = n;
    o.stat  = st;
    return o;
  endfunction

  function automatic request_t rand_fields();
    return mk(3'($urandom_range(0, 7)), 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 14'($urandom));
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (err_cnt < 100)
      $display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Offer one transaction, hold it until accepted, then log its expectation.
  task automatic send_req(input request_t r, input logic use_typed, input result_t typed_res,
                          output result_t pred);
    @(negedge clk);
    in_valid  = 1'b1;
    req_type  = r.req;
    byte_in   = r.stream_byte;
    total     = r.total;
    start_req = r.start;
    size      = r.size;
    size0     = r.size0;
    do @(posedge clk); while (!in_ready);
    pred = decode_step(r);
    pending_q.push_back(use_typed ? typed_res : pred);
    req_cnt[r.req]++;
    sent_cnt++;
  endtask

  task automatic tx_gap(input int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic put(input request_t r, output result_t pred);
    send_req(r, 1'b0, '0, pred);
    if ($urandom_range(0, 49) == 0) tx_busy = ~tx_busy;
    if (!quiet && tx_busy && $urandom_range(0, 3) == 0) tx_gap($urandom_range(1, 19));
  endtask

  // Feed the renormalization bytes asked for; now and then feed a wrong count.
  task automatic feed_bytes(input logic [1:0] n);
    request_t r;
    result_t  p;
    int       cnt;
    cnt = n;
    if ($urandom_range(0, 14) == 0) cnt = $urandom_range(0, 3);
    repeat (cnt) begin
      r     = rand_fields();
      r.req = REQ_BYTE;
      put(r, p);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        report("result with nothing pending, count_out", count_out, 32'h0);
      end else begin
        mon_want = pending_q.pop_front();
        checked_cnt++;
        if (count_out !== mon_want.count) report("count_out", count_out, mon_want.count);
        if (bit_out !== mon_want.dbit) report("bit_out", bit_out, mon_want.dbit);
        if (bytes_needed !== mon_want.need)
          report("bytes_needed", bytes_needed, mon_want.need);
        if (status !== mon_want.stat) report("status", status, mon_want.stat);
      end
    end
  end

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cyc_cnt, pending_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Output side: random stall bursts, one long hold-off on request.
  initial begin : rx_side
    int n;
    int hold_cyc;
    logic rx_busy;
    out_ready = 1'b0;
    rx_busy   = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 255) == 0) rx_busy = ~rx_busy;
      if (hold_req) begin
        out_ready = 1'b0;
        for (hold_cyc = 0; hold_cyc < HOLD_CYCLES; hold_cyc++) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && rx_busy && $urandom_range(0, 7) == 0) begin
        out_ready = 1'b0;
        n = $urandom_range(1, 19);
        repeat (n) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin : stim
    int       i;
    int       k;
    int       choice;
    int       thr_total;
    logic     paused;
    logic     held;
    logic [31:0] cnt;
    request_t r;
    result_t  p;

    in_valid    = 1'b0;
    req_type    = REQ_START;
    byte_in     = '0;
    total       = '0;
    start_req   = '0;
    size        = '0;
    size0       = '0;
    rst         = 1'b1;
    quiet       = 1'b0;
    tx_busy     = 1'b1;
    hold_req    = 1'b0;
    paused      = 1'b0;
    held        = 1'b0;
    sent_cnt    = 0;
    checked_cnt = 0;
    err_cnt     = 0;
    cyc_cnt     = 0;
    code_q      = '0;
    range_q     = ALL_ONES;
    load_cnt    = '0;
    err_sticky  = 1'b0;
    for (i = 0; i < 8; i++) req_cnt[i] = 0;

    // load, operate on the extremes, shift after load, reserved codes
    dir_tab[0]  = '{mk(REQ_START, 8'h00, 16'h0000, 16'h0000, 16'h0000, 14'h0000), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_OK)};
    dir_tab[1]  = '{mk(REQ_BYTE, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_OK)};
    dir_tab[2]  = '{mk(REQ_BYTE, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 14'h0000), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_OK)};
    dir_tab[3]  = '{mk(REQ_BYTE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 14'h0000), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_OK)};
    dir_tab[4]  = '{mk(REQ_BYTE, 8'h80, 16'h0000, 16'h0000, 16'h0000, 14'h0000), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_OK)};
    dir_tab[5]  = '{mk(REQ_BYTE, 8'h7F, 16'h0000, 16'h0000, 16'h0000, 14'h0000), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_OK)};
    dir_tab[6]  = '{mk(REQ_THRESH, 8'hFF, 16'h0000, 16'hFFFF, 16'hFFFF, 14'h3FFF), 1'b1,
                    rs(ALL_ONES, 1'b0, 2'd0, STAT_DIV_ZERO)};
    dir_tab[7]  = '{mk(REQ_THRESH, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 14'h0000), 1'b0, '0};
    dir_tab[8]  = '{mk(REQ_DECODE, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 14'h0000), 1'b0, '0};
    dir_tab[9]  = '{mk(REQ_BIT, 8'h00, 16'h0000, 16'h0000, 16'h0000, 14'h3FFF), 1'b0, '0};
    dir_tab[10] = '{mk(REQ_BIT, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h0000), 1'b0, '0};
    dir_tab[11] = '{mk(REQ_BYTE, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 14'h0000), 1'b0, '0};
    dir_tab[12] = '{mk(REQ_RSVD_5, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_OK)};
    dir_tab[13] = '{mk(REQ_RSVD_7, 8'h00, 16'h0000, 16'h0000, 16'h0000, 14'h0000), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_OK)};
    // bad marker byte, then the sticky flag and the zero-divisor cases
    dir_tab[14] = '{mk(REQ_START, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_OK)};
    dir_tab[15] = '{mk(REQ_BYTE, 8'h01, 16'h0000, 16'h0000, 16'h0000, 14'h0000), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_FIRST_BYTE)};
    dir_tab[16] = '{mk(REQ_BYTE, 8'hFF, 16'h0000, 16'h0000, 16'h0000, 14'h0000), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_FIRST_BYTE)};
    dir_tab[17] = '{mk(REQ_RSVD_6, 8'h5A, 16'h1234, 16'h5678, 16'h9ABC, 14'h1555), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_FIRST_BYTE)};
    dir_tab[18] = '{mk(REQ_THRESH, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 14'h0000), 1'b0, '0};
    dir_tab[19] = '{mk(REQ_DECODE, 8'h00, 16'h0000, 16'h0000, 16'h0001, 14'h0000), 1'b0, '0};
    dir_tab[20] = '{mk(REQ_THRESH, 8'h00, 16'hFFFF, 16'h0000, 16'h0000, 14'h0000), 1'b0, '0};
    dir_tab[21] = '{mk(REQ_THRESH, 8'h00, 16'h0002, 16'h0000, 16'h0000, 14'h0000), 1'b1,
                    rs(ALL_ONES, 1'b0, 2'd0, STAT_DIV_ZERO)};
    dir_tab[22] = '{mk(REQ_DECODE, 8'h00, 16'h0000, 16'hFFFF, 16'hFFFF, 14'h0000), 1'b0, '0};
    dir_tab[23] = '{mk(REQ_THRESH, 8'h00, 16'h0001, 16'h0000, 16'h0000, 14'h0000), 1'b1,
                    rs(ALL_ONES, 1'b0, 2'd0, STAT_DIV_ZERO)};
    dir_tab[24] = '{mk(REQ_START, 8'h00, 16'h0000, 16'h0000, 16'h0000, 14'h0000), 1'b1,
                    rs(32'h0, 1'b0, 2'd0, STAT_OK)};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (i = 0; i < DIR_N; i++) begin
      send_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].res, p);
      if ($urandom_range(0, 2) == 0) tx_gap($urandom_range(1, 19));
    end

    while (sent_cnt < DIR_N + RAND_ITEMS) begin
      quiet = (sent_cnt >= DIR_N + RAND_ITEMS - QUIET_TAIL);
      // drain completely once, then hold the output side off while offering
      if (!paused && sent_cnt >= DIR_N + PAUSE_AT) begin
        paused = 1'b1;
        tx_gap(1);
        while (pending_q.size() != 0) @(posedge clk);
      end
      if (!held && sent_cnt >= DIR_N + HOLD_AT) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      choice = $urandom_range(0, 99);
      if (choice < 7) begin
        r     = rand_fields();
        r.req = REQ_START;
        put(r, p);
        for (k = 0; k < 5; k++) begin
          r     = rand_fields();
          r.req = REQ_BYTE;
          if (k == 0 && $urandom_range(0, 9) != 0) r.stream_byte = 8'h00;
          put(r, p);
        end
      end else if (choice < 52) begin
        r         = rand_fields();
        r.req     = REQ_THRESH;
        r.total   = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
        thr_total = r.total;
        put(r, p);
        cnt   = p.count;
        r     = rand_fields();
        r.req = REQ_DECODE;
        // pick an interval that holds the threshold, as a real model would
        if (p.stat != STAT_DIV_ZERO && cnt < thr_total) begin
          r.start = 16'($urandom_range(0, cnt));
          r.size  = 16'($urandom_range(cnt - r.start + 1, thr_total - r.start));
        end
        put(r, p);
        feed_bytes(p.need);
      end else if (choice < 85) begin
        r     = rand_fields();
        r.req = REQ_BIT;
        put(r, p);
        feed_bytes(p.need);
      end else begin
        r = rand_fields();
        put(r, p);
      end
    end

    tx_gap(1);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transactions: %0d start, %0d byte, %0d threshold, %0d decode, %0d bit,",
             sent_cnt, req_cnt[REQ_START], req_cnt[REQ_BYTE], req_cnt[REQ_THRESH],
             req_cnt[REQ_DECODE], req_cnt[REQ_BIT]);
    $display("%0d reserved; %0d results compared, %0d mismatches",
             req_cnt[REQ_RSVD_5] + req_cnt[REQ_RSVD_6] + req_cnt[REQ_RSVD_7],
             checked_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
